// File: src/wrpk_pkg.sv
// ----------------------------------------------------------------------------
// wrpk_pkg
// Shared types, field widths and codes for the weighted random pick block.
// ----------------------------------------------------------------------------
package wrpk_pkg;

    // Field widths of the request and result channels
    localparam int ID_W   = 16;
    localparam int WGT_W  = 5;
    localparam int RND_W  = 16;
    localparam int STAT_W = 2;
    localparam int TOTO_W = 9;

    // Request codes
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_PICK = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_COMPACT,
        ST_RESP
    } wrpk_state_t;

endpackage

// File: src/wrpk_req_if.sv
// ----------------------------------------------------------------------------
// wrpk_req_if
// Request channel: valid/ready handshake with the add/pick request payload.
// ----------------------------------------------------------------------------
interface wrpk_req_if;
    import wrpk_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [ID_W-1:0]  item_id;
    logic [WGT_W-1:0] weight;
    logic [RND_W-1:0] random_value;

    modport source (
        output valid,
        output req_type,
        output item_id,
        output weight,
        output random_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  item_id,
        input  weight,
        input  random_value,
        output ready
    );

endinterface

// File: src/wrpk_rsp_if.sv
// ----------------------------------------------------------------------------
// wrpk_rsp_if
// Result channel: valid/ready handshake with the pick result payload.
// ----------------------------------------------------------------------------
interface wrpk_rsp_if;
    import wrpk_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   picked_id;
    logic [STAT_W-1:0] status;
    logic [TOTO_W-1:0] total_weight_now;

    modport source (
        output valid,
        output picked_id,
        output status,
        output total_weight_now,
        input  ready
    );

    modport sink (
        input  valid,
        input  picked_id,
        input  status,
        input  total_weight_now,
        output ready
    );

endinterface

// File: src/wrpk_ram.sv
// ----------------------------------------------------------------------------
// wrpk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wrpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write into the array, read data registered; a read of the address being written returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/wrpk_mod.sv
// ----------------------------------------------------------------------------
// wrpk_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wrpk_mod #(
    parameter int DVD_W = 16,
    parameter int DIV_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W-1:0] rem_reg, rem_next;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic             last_step;

    // Shift in the next dividend bit and try the subtraction
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff      = trial - {1'b0, div_reg};
    assign fits      = (trial >= {1'b0, div_reg});
    assign last_step = (cnt_reg == CNT_W'(DVD_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: src/weighted_random_pick_without_replacement_top.sv
// Sequence: an add records its status in the result register and goes straight to the
// response state; a pick first runs the remainder unit, then a walk of
// the table to the chosen entry, then a compaction pass over all N entries.
// Throughput: one request at a time; the pick time is set by the bit-serial
// remainder unit and the single read port of the entry RAM.
// Reset: entry count, total weight, controller and result valid are cleared.
// ----------------------------------------------------------------------------
// weighted_random_pick_without_replacement_top
// Ordered (id, weight) table in RAM with weighted random pick and removal.
// ----------------------------------------------------------------------------
module weighted_random_pick_without_replacement_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int MAX_WEIGHT  = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    wrpk_req_if.sink   req,
    wrpk_rsp_if.source rsp
);
    import wrpk_pkg::*;

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int TOTAL_W = $clog2(MAX_ENTRIES * ((1 << WGT_W) - 1) + 1);
    localparam int MEM_W   = ID_W + WGT_W;

    wrpk_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic [CNT_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [TOTAL_W-1:0] acc_reg, acc_next;
    logic [TOTAL_W-1:0] target_reg, target_next;
    logic [ID_W-1:0]   chosen_reg, chosen_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [TOTO_W-1:0] out_total_reg, out_total_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [MEM_W-1:0]  ram_wdata;
    logic [MEM_W-1:0]  ram_rdata;

    logic              mod_start;
    logic              mod_done;
    logic [TOTAL_W-1:0] mod_rem;

    logic              in_xfer;
    logic              out_free;
    logic              pick_empty;
    logic              add_full;
    logic [WGT_W-1:0]  w_sat;
    logic [WGT_W-1:0]  rd_w;
    logic [ID_W-1:0]   rd_id;
    logic [TOTAL_W-1:0] acc_sum;
    logic              issue;
    logic              last_issue;
    logic              scan_hit;
    logic              keep;
    logic              comp_done;
    logic [TOTAL_W+TOTO_W-1:0] total_ext;

    // Entry table: {id, weight} per entry
    wrpk_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Random value modulo the running total
    wrpk_mod #(
        .DVD_W (RND_W),
        .DIV_W (TOTAL_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (req.random_value),
        .divisor  (total_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Handshake and shared terms
    assign req.ready  = (state_reg == ST_IDLE);
    assign in_xfer    = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign pick_empty = (count_reg == '0) || (total_reg == '0);
    assign add_full   = (count_reg == CNT_W'(MAX_ENTRIES));
    assign w_sat      = ({3'b000, req.weight} > 8'(MAX_WEIGHT)) ? WGT_W'(MAX_WEIGHT)
                                                                 : req.weight;

    // Read data of the entry walk
    assign rd_w       = ram_rdata[WGT_W-1:0];
    assign rd_id      = ram_rdata[MEM_W-1:WGT_W];
    assign acc_sum    = acc_reg + TOTAL_W'(rd_w);
    assign issue      = (rd_idx_reg < count_reg);
    assign last_issue = (rd_idx_reg == count_reg - CNT_W'(1));
    assign scan_hit   = pend_reg && ((target_reg < acc_sum) || pend_last_reg);
    assign keep       = (rd_id != chosen_reg);
    assign comp_done  = pend_reg && pend_last_reg;
    assign total_ext  = (TOTAL_W + TOTO_W)'(total_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (req.req_type == REQ_PICK && !pick_empty)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = ST_COMPACT;
                end
            end
            ST_COMPACT:
            begin
                if (comp_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result register
    always_comb
    begin
        count_next      = count_reg;
        total_next      = total_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = 1'b0;
        pend_last_next  = pend_last_reg;
        wr_idx_next     = wr_idx_reg;
        acc_next        = acc_reg;
        target_next     = target_reg;
        chosen_next     = chosen_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_W-1:0];
        ram_wdata       = {req.item_id, w_sat};
        mod_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_id_next     = '0;
                    res_status_next = STAT_DONE;
                    if (req.req_type == REQ_ADD)
                    begin
                        if (w_sat == '0)
                        begin
                            res_status_next = STAT_DONE;
                        end
                        else if (add_full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            total_next = total_reg + TOTAL_W'(w_sat);
                        end
                    end
                    else if (pick_empty)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        mod_start = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    target_next = mod_rem;
                    rd_idx_next = '0;
                    acc_next    = '0;
                end
            end
            ST_SCAN:
            begin
                // Walk cumulative weights until the target falls in range
                if (scan_hit)
                begin
                    chosen_next = rd_id;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    acc_next    = '0;
                end
                else
                begin
                    if (pend_reg)
                    begin
                        acc_next = acc_sum;
                    end
                    if (issue)
                    begin
                        pend_next      = 1'b1;
                        pend_last_next = last_issue;
                        rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_COMPACT:
            begin
                // Copy down every entry not carrying the chosen id
                if (issue)
                begin
                    pend_next      = 1'b1;
                    pend_last_next = last_issue;
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                end
                if (pend_reg && keep)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_idx_reg[IDX_W-1:0];
                    ram_wdata   = ram_rdata;
                    wr_idx_next = wr_idx_reg + CNT_W'(1);
                    acc_next    = acc_sum;
                end
                if (comp_done)
                begin
                    count_next      = keep ? wr_idx_reg + CNT_W'(1) : wr_idx_reg;
                    total_next      = keep ? acc_sum : acc_reg;
                    res_id_next     = chosen_reg;
                    res_status_next = STAT_DONE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = res_id_reg;
                    out_status_next = res_status_reg;
                    out_total_next  = total_ext[TOTO_W-1:0];
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !rsp.ready;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            wr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            wr_idx_reg    <= wr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_last_reg  <= pend_last_next;
        acc_reg        <= acc_next;
        target_reg     <= target_next;
        chosen_reg     <= chosen_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.picked_id        = out_id_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.total_weight_now = out_total_reg;

`ifndef ASSERT_OFF
    // Entry count never exceeds the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // Compaction writes never overtake the read pointer
    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPACT) |-> (wr_idx_reg <= rd_idx_reg))
        else $error("compaction write overtook read");

    // Remainder unit finishes only while the controller waits for it
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_DIV))
        else $error("remainder result outside divide phase");

    // Empty table and zero total go together between requests
    a_total_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((count_reg == '0) == (total_reg == '0)))
        else $error("total weight and entry count disagree");

    // An empty pick reports a zero id
    a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STAT_EMPTY) |-> (out_id_reg == '0))
        else $error("empty pick with non-zero id");
`endif

endmodule
